// ===== src/conv3_pkg.sv =====
// Shared types and constants of the 3x3 convolution unit.
// Depends on nothing; every other file imports it.
package conv3_pkg;

   localparam int PIX_W       = 8;
   localparam int WEIGHTS_W   = 3 * PIX_W;
   localparam int WIDTH_REG_W = 11;
   localparam int LINES_REG_W = 13;
   localparam int MAX_LINES   = 4096;
   localparam int CSR_INDEX_W = 3;
   localparam int DOT_W       = 2 * PIX_W + 2;
   localparam int SUM_W       = DOT_W + 2;

   localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
   localparam logic [LINES_REG_W-1:0] LINES_RESET = 13'd1024;

   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTS_TOP    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTS_MIDDLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHTS_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_LINES    = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic             row_end;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] middle;
      logic [PIX_W-1:0] bottom;
   } pix3_type;

endpackage

// ===== src/conv3_line_store.sv =====
// Two padded line stores kept as one memory of pixel pairs, with registered read.
// A read of the address written in the same cycle is forwarded. Uses conv3_pkg.
module conv3_line_store
   import conv3_pkg::*;
#(
   parameter int DEPTH = 1026,
   parameter int AW    = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic [AW-1:0]      rd_addr,
   input  logic               wr_valid,
   input  logic [AW-1:0]      wr_addr,
   input  logic [2*PIX_W-1:0] wr_data,
   output logic [2*PIX_W-1:0] rd_data
);

   logic [2*PIX_W-1:0] mem [DEPTH];
   logic [2*PIX_W-1:0] rd_q_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;
   logic               fwd_in;

   assign fwd_in = wr_valid && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (enable) begin
         rd_q_ff     <= mem[rd_addr];
         fwd_data_ff <= wr_data;
         if (wr_valid) begin
            mem[wr_addr] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (enable) begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_q_ff;

endmodule

// ===== src/conv3_column_cell.sv =====
// One window column: holds three pixels, passes them to its neighbor on each
// shift and registers their dot product with its column of weights. Uses conv3_pkg.
module conv3_column_cell
   import conv3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             shift,
   input  pix3_type         col_in,
   input  pix3_type         weights,
   output pix3_type         col_out,
   output logic [DOT_W-1:0] dot
);

   pix3_type         col_ff;
   logic [DOT_W-1:0] dot_ff;
   logic [DOT_W-1:0] dot_in;

   assign dot_in = DOT_W'(col_ff.top * weights.top)
                 + DOT_W'(col_ff.middle * weights.middle)
                 + DOT_W'(col_ff.bottom * weights.bottom);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (enable && shift) begin
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dot_ff <= dot_in;
      end
   end

   assign col_out = col_ff;
   assign dot     = dot_ff;

endmodule

// ===== src/conv3x3_u8_line_buffered_unit.sv =====
// Top level of the 3x3 convolution unit: position counters, line stores, column cells
// and the output register with skid stage. Uses conv3_pkg and all other modules.
//
// The unit takes one padded pixel per clock and gives one output pixel per clock
// once the window is inside the image, unless a result waits in the skid stage. A
// pixel is handled in order: the line store is read on the accepting edge, then come
// the window shift, the dot products, and the sum with saturation into the output
// register. The line store memory is read once and written once per pixel through
// separate ports, which sets the rate at one pixel per clock unless stalled. Configuration
// must be written only while idle; the block does not enforce this. The line stores need no clearing after reset.
module conv3x3_u8_line_buffered_unit
   import conv3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WEIGHTS_W-1:0]   csr_data
);

   localparam int STORE_DEPTH = MAX_WIDTH + 2;
   localparam int COL_W       = $clog2(STORE_DEPTH);

   logic [WEIGHTS_W-1:0]   w_top_ff, w_mid_ff, w_bot_ff;
   logic [WIDTH_REG_W-1:0] width_ff;
   logic [LINES_REG_W-1:0] lines_ff;

   logic [COL_W-1:0]       col_ff, col_in, col_cur, w_eff, w_end;
   logic [LINES_REG_W-1:0] row_ff, row_in, row_cur, l_eff, l_end;
   logic                   accept, adv, emit;

   logic                   s1_valid_ff, s1_emit_ff, s1_row_end_ff, s1_frame_end_ff;
   logic [PIX_W-1:0]       s1_pixel_ff;
   logic [COL_W-1:0]       s1_addr_ff;
   logic                   s2_valid_ff, s2_emit_ff, s2_row_end_ff, s2_frame_end_ff;
   logic                   s3_valid_ff, s3_emit_ff, s3_row_end_ff, s3_frame_end_ff;

   logic [2*PIX_W-1:0]     store_rd, store_wr;
   pix3_type               new_col, col2, col1;
   pix3_type               wcol [3];
   logic [DOT_W-1:0]       dot0, dot1, dot2;
   logic [SUM_W-1:0]       sum;
   logic [SUM_W-PIX_W-1:0] shifted;
   rsp_type                result;
   logic                   produce;

   rsp_type                rsp_ff, rsp_in, skid_ff, skid_in;
   logic                   rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_top_ff <= '0;
         w_mid_ff <= '0;
         w_bot_ff <= '0;
         width_ff <= WIDTH_RESET;
         lines_ff <= LINES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WEIGHTS_TOP:    w_top_ff <= csr_data;
            CSR_WEIGHTS_MIDDLE: w_mid_ff <= csr_data;
            CSR_WEIGHTS_BOTTOM: w_bot_ff <= csr_data;
            CSR_IMAGE_WIDTH:    width_ff <= csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_LINES:    lines_ff <= csr_data[LINES_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(width_ff);
      end
      if (lines_ff == '0) begin
         l_eff = LINES_REG_W'(1);
      end else if (32'(lines_ff) > MAX_LINES) begin
         l_eff = LINES_REG_W'(MAX_LINES);
      end else begin
         l_eff = lines_ff;
      end
   end

   assign w_end = w_eff + COL_W'(1);
   assign l_end = l_eff + LINES_REG_W'(1);

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   assign col_cur = req_data.frame_start ? '0 : col_ff;
   assign row_cur = req_data.frame_start ? '0 : row_ff;
   assign emit    = (row_cur >= LINES_REG_W'(2)) && (row_cur <= l_end)
                 && (col_cur >= COL_W'(2)) && (col_cur <= w_end);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_cur >= w_end) begin
            col_in = '0;
            row_in = (row_cur >= l_end) ? '0 : row_cur + LINES_REG_W'(1);
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_emit_ff      <= emit;
         s1_row_end_ff   <= col_cur == w_end;
         s1_frame_end_ff <= (col_cur == w_end) && (row_cur == l_end);
         s1_pixel_ff     <= req_data.pixel;
         s1_addr_ff      <= col_cur;
         s2_emit_ff      <= s1_emit_ff;
         s2_row_end_ff   <= s1_row_end_ff;
         s2_frame_end_ff <= s1_frame_end_ff;
         s3_emit_ff      <= s2_emit_ff;
         s3_row_end_ff   <= s2_row_end_ff;
         s3_frame_end_ff <= s2_frame_end_ff;
      end
   end

   assign store_wr = {store_rd[PIX_W-1:0], s1_pixel_ff};

   conv3_line_store #(
      .DEPTH(STORE_DEPTH),
      .AW   (COL_W)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .enable  (adv),
      .rd_addr (col_cur),
      .wr_valid(s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (store_wr),
      .rd_data (store_rd)
   );

   assign new_col.top    = store_rd[2*PIX_W-1:PIX_W];
   assign new_col.middle = store_rd[PIX_W-1:0];
   assign new_col.bottom = s1_pixel_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wcol[k].top    = w_top_ff[k*PIX_W +: PIX_W];
         wcol[k].middle = w_mid_ff[k*PIX_W +: PIX_W];
         wcol[k].bottom = w_bot_ff[k*PIX_W +: PIX_W];
      end
   end

   conv3_column_cell u_cell2 (
      .clock  (clock),
      .reset  (reset),
      .enable (adv),
      .shift  (s1_valid_ff),
      .col_in (new_col),
      .weights(wcol[2]),
      .col_out(col2),
      .dot    (dot2)
   );

   conv3_column_cell u_cell1 (
      .clock  (clock),
      .reset  (reset),
      .enable (adv),
      .shift  (s1_valid_ff),
      .col_in (col2),
      .weights(wcol[1]),
      .col_out(col1),
      .dot    (dot1)
   );

   conv3_column_cell u_cell0 (
      .clock  (clock),
      .reset  (reset),
      .enable (adv),
      .shift  (s1_valid_ff),
      .col_in (col1),
      .weights(wcol[0]),
      .col_out(),
      .dot    (dot0)
   );

   assign sum     = SUM_W'(dot0) + SUM_W'(dot1) + SUM_W'(dot2);
   assign shifted = sum[SUM_W-1:PIX_W];

   always_comb begin
      result.value     = (|shifted[SUM_W-PIX_W-1:PIX_W]) ? '1 : shifted[PIX_W-1:0];
      result.row_end   = s3_row_end_ff;
      result.frame_end = s3_frame_end_ff;
   end

   assign produce = adv && s3_valid_ff && s3_emit_ff;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (produce) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a transaction while the output register is empty");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      (produce && rsp_valid_ff && !rsp_ready) |=> (skid_valid_ff && rsp_valid_ff))
      else $error("result produced during an output stall was not kept");

   a_column_in_store: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) <= MAX_WIDTH + 1)
      else $error("column position beyond the line store");

   a_frame_end_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.frame_end || rsp_ff.row_end))
      else $error("frame end mark without row end mark");

endmodule
